// ----- rtl/ftcr_pkg.sv -----
// types and codes shared by the frame table clock replacement unit
`timescale 1ns / 1ps
package ftcr_pkg;

  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_TOUCH  = 3'd1;
  localparam logic [2:0] REQ_PIN    = 3'd2;
  localparam logic [2:0] REQ_EVICT  = 3'd3;
  localparam logic [2:0] REQ_SEARCH = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [19:0] page_number;
    logic [5:0]  owner_id;
    logic        start_pinned;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [19:0] victim_page;
    logic [5:0]  victim_owner;
  } res_t;

  typedef struct packed {
    logic [19:0] page;
    logic [5:0]  owner;
    logic        accessed;
    logic        pinned;
  } entry_t;

endpackage

// ----- rtl/ftcr_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ftcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/frame_table_clock_replacement_unit.sv -----
// frame table with second-chance victim selection, held in one ram
// insert: written from idle, then result; touch, pin, search: each entry read then checked until a hit
// evict: scan steps (at most 2*count) each read then check, then entries after the victim shift down
// one request at a time; each scanned entry takes a ram read step then a check step
// synchronous reset empties the table (count to zero) and drops out_valid
`timescale 1ns / 1ps
module frame_table_clock_replacement_unit #(
  parameter int NUM_FRAMES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ftcr_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ftcr_pkg::res_t out_data
);
  import ftcr_pkg::*;

  localparam int AW = $clog2(NUM_FRAMES);
  localparam int CW = AW + 1;
  localparam int SW = AW + 2;
  localparam int EW = $bits(entry_t);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_CHK    = 3'd2;
  localparam logic [2:0] S_SH_RD  = 3'd3;
  localparam logic [2:0] S_SH_CHK = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]  state, state_next;
  req_t        req, req_next;
  logic [AW-1:0] idx, idx_next;
  logic [SW-1:0] step, step_next;
  logic [CW-1:0] count, count_next;
  res_t        res, res_next;
  logic        out_valid_next;
  res_t        out_data_next;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wentry, rentry;
  logic [EW-1:0] rdata;

  logic [CW-1:0] idx_inc;
  logic [SW-1:0] step_inc;
  logic          hit;

  ftcr_ram #(.WIDTH(EW), .DEPTH(NUM_FRAMES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rentry   = entry_t'(rdata);
  assign in_ready = (state == S_IDLE);
  assign idx_inc  = CW'(idx) + CW'(1);
  assign step_inc = step + SW'(1);
  assign raddr    = (state == S_SH_RD) ? AW'(idx_inc) : idx;
  assign hit      = (rentry.page == req.page_number) &&
                    ((req.req_type != REQ_TOUCH) || (rentry.owner == req.owner_id));

  always_comb begin
    state_next     = state;
    req_next       = req;
    idx_next       = idx;
    step_next      = step;
    count_next     = count;
    res_next       = res;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    we             = 1'b0;
    waddr          = idx;
    wentry         = rentry;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_next  = in_data;
          idx_next  = '0;
          step_next = '0;
          res_next  = '{status: ST_NOT_FOUND, slot: '0, victim_page: '0, victim_owner: '0};
          state_next = S_DONE;
          if (in_data.req_type == REQ_INSERT) begin
            if (count == CW'(NUM_FRAMES)) begin
              res_next.status = ST_FULL;
            end else begin
              we          = 1'b1;
              waddr       = AW'(count);
              wentry      = '{page: in_data.page_number, owner: in_data.owner_id,
                              accessed: 1'b0, pinned: in_data.start_pinned};
              count_next  = count + CW'(1);
              res_next.status = ST_OK;
              res_next.slot   = 6'(count);
            end
          end else if ((in_data.req_type == REQ_TOUCH) || (in_data.req_type == REQ_PIN) ||
                       (in_data.req_type == REQ_SEARCH) || (in_data.req_type == REQ_EVICT)) begin
            if (count != '0) begin
              state_next = S_RD;
            end
          end
        end
      end
      S_RD: state_next = S_CHK;
      S_CHK: begin
        if (req.req_type == REQ_EVICT) begin
          if (!rentry.pinned && !rentry.accessed) begin
            res_next = '{status: ST_OK, slot: 6'(idx), victim_page: rentry.page,
                         victim_owner: rentry.owner};
            if (idx_inc < count) begin
              state_next = S_SH_RD;
            end else begin
              count_next = count - CW'(1);
              state_next = S_DONE;
            end
          end else begin
            if (!rentry.pinned) begin
              // second chance: drop the accessed bit
              we              = 1'b1;
              wentry.accessed = 1'b0;
            end
            step_next = step_inc;
            if (step_inc == {count, 1'b0}) begin
              state_next = S_DONE;
            end else begin
              idx_next   = (idx_inc >= count) ? '0 : AW'(idx_inc);
              state_next = S_RD;
            end
          end
        end else if (hit) begin
          res_next.status = ST_OK;
          res_next.slot   = 6'(idx);
          if (req.req_type == REQ_TOUCH) begin
            we              = 1'b1;
            wentry.accessed = 1'b1;
          end else if (req.req_type == REQ_PIN) begin
            we            = 1'b1;
            wentry.pinned = 1'b1;
          end else begin
            res_next.victim_page  = rentry.page;
            res_next.victim_owner = rentry.owner;
          end
          state_next = S_DONE;
        end else if (idx_inc >= count) begin
          state_next = S_DONE;
        end else begin
          idx_next   = AW'(idx_inc);
          state_next = S_RD;
        end
      end
      S_SH_RD: state_next = S_SH_CHK;
      S_SH_CHK: begin
        // compaction: move entry idx+1 down to idx
        we       = 1'b1;
        idx_next = AW'(idx_inc);
        if ((idx_inc + CW'(1)) < count) begin
          state_next = S_SH_RD;
        end else begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    req      <= req_next;
    idx      <= idx_next;
    step     <= step_next;
    res      <= res_next;
    out_data <= out_data_next;
  end
endmodule

// ----- tb/testbench.sv -----
// testbench for the frame table clock replacement unit
`timescale 1ns / 1ps
module testbench;
  import ftcr_pkg::*;

  localparam int FRAMES = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;

  frame_table_clock_replacement_unit #(.NUM_FRAMES(FRAMES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // shadow frame table
  entry_t table_q [$];
  res_t expected_results [$];
  int mismatch_count = 0;
  int error_count = 0;
  int idle_cycles = 0;
  bit hold_output = 1'b0;
  bit drain_done = 1'b0;

  function automatic res_t predict_frame_request(req_t r);
    res_t o;
    int idx;
    int pos;
    entry_t e;
    o = '0;
    o.status = ST_NOT_FOUND;
    idx = -1;
    case (r.req_type)
      REQ_INSERT: begin
        if (table_q.size() >= FRAMES) begin
          o.status = ST_FULL;
        end else begin
          e.page = r.page_number;
          e.owner = r.owner_id;
          e.accessed = 1'b0;
          e.pinned = r.start_pinned;
          o.status = ST_OK;
          o.slot = 6'(table_q.size());
          table_q.push_back(e);
        end
      end
      REQ_TOUCH, REQ_PIN, REQ_SEARCH: begin
        foreach (table_q[i]) begin
          if (idx < 0 && table_q[i].page == r.page_number &&
              (r.req_type != REQ_TOUCH || table_q[i].owner == r.owner_id)) idx = i;
        end
        if (idx >= 0) begin
          o.status = ST_OK;
          o.slot = 6'(idx);
          if (r.req_type == REQ_TOUCH) table_q[idx].accessed = 1'b1;
          else if (r.req_type == REQ_PIN) table_q[idx].pinned = 1'b1;
          else begin
            o.victim_page = table_q[idx].page;
            o.victim_owner = table_q[idx].owner;
          end
        end
      end
      REQ_EVICT: begin
        pos = 0;
        for (int s = 0; s < 2 * table_q.size(); s++) begin
          if (!table_q[pos].pinned) begin
            if (table_q[pos].accessed) table_q[pos].accessed = 1'b0;
            else begin
              o.status = ST_OK;
              o.slot = 6'(pos);
              o.victim_page = table_q[pos].page;
              o.victim_owner = table_q[pos].owner;
              table_q.delete(pos);
              return o;
            end
          end
          pos++;
          if (pos >= table_q.size()) pos = 0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // valid stays high after the accepting edge until the next falling edge,
  // where it either carries the next transaction or drops
  task automatic send_request(logic [2:0] kind, logic [19:0] page, logic [5:0] owner,
                              logic pin, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(4);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= '{req_type: kind, page_number: page, owner_id: owner, start_pinned: pin};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_frame_request(in_data));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (mismatch_count++ < 10) $display("unexpected transaction %p", out_data);
      end else begin
        res_t x;
        x = expected_results.pop_front();
        if (out_data.status !== x.status || out_data.slot !== x.slot ||
            out_data.victim_page !== x.victim_page ||
            out_data.victim_owner !== x.victim_owner) begin
          error_count++;
          if (mismatch_count++ < 10) $display("mismatch: expected %p actual %p", x, out_data);
        end
      end
    end
  end

  // receiver stalls
  always begin
    int wait_cycles;
    @(negedge clk);
    if (hold_output) begin
      out_ready <= 1'b0;
    end else begin
      wait_cycles = $urandom_range(4);
      if (wait_cycles != 0 && $urandom_range(3) != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [19:0] pick_page();
    if (table_q.size() != 0 && $urandom_range(3) != 0)
      return table_q[$urandom_range(table_q.size() - 1)].page;
    return 20'($urandom_range(15));
  endfunction

  task automatic test_directed();
    send_request(REQ_EVICT, 20'h0, 6'h0, 1'b0);
    send_request(REQ_SEARCH, 20'hfffff, 6'h3f, 1'b0);
    send_request(REQ_INSERT, 20'hfffff, 6'h3f, 1'b0);
    send_request(REQ_INSERT, 20'h0, 6'h0, 1'b1);
    send_request(REQ_INSERT, 20'h5a5a5, 6'h2a, 1'b0);
    send_request(REQ_INSERT, 20'hfffff, 6'h15, 1'b0);
    send_request(REQ_TOUCH, 20'hfffff, 6'h15, 1'b0);
    send_request(REQ_TOUCH, 20'hfffff, 6'h3f, 1'b0);
    send_request(REQ_TOUCH, 20'h12345, 6'h3f, 1'b0);
    send_request(REQ_PIN, 20'h5a5a5, 6'h0, 1'b0);
    send_request(REQ_PIN, 20'h11111, 6'h0, 1'b0);
    send_request(REQ_SEARCH, 20'hfffff, 6'h0, 1'b0);
    send_request(REQ_SEARCH, 20'h0, 6'h0, 1'b0);
    send_request(3'd5, 20'hfffff, 6'h3f, 1'b1);
    send_request(3'd6, 20'h0, 6'h0, 1'b0);
    send_request(3'd7, 20'h1, 6'h1, 1'b1);
    send_request(REQ_EVICT, 20'h0, 6'h0, 1'b0);
    send_request(REQ_EVICT, 20'h0, 6'h0, 1'b0);
    send_request(REQ_EVICT, 20'h0, 6'h0, 1'b0);
  endtask

  // one evict, then fill to full with random pins and try two inserts past full
  task automatic test_full_table();
    send_request(REQ_EVICT, 20'h0, 6'h0, 1'b0);
    while (table_q.size() < FRAMES)
      send_request(REQ_INSERT, 20'($urandom), 6'($urandom), 1'($urandom));
    send_request(REQ_INSERT, 20'h1, 6'h1, 1'b0);
    send_request(REQ_INSERT, 20'hfffff, 6'h3f, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [2:0] kind;
    int sel;
    entry_t e;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 28) kind = REQ_INSERT;
      else if (sel < 50) kind = REQ_TOUCH;
      else if (sel < 60) kind = REQ_PIN;
      else if (sel < 82) kind = REQ_EVICT;
      else if (sel < 97) kind = REQ_SEARCH;
      else kind = 3'($urandom_range(7, 5));
      if (kind == REQ_TOUCH && table_q.size() != 0 && $urandom_range(3) != 0) begin
        e = table_q[$urandom_range(table_q.size() - 1)];
        send_request(kind, e.page, e.owner, 1'($urandom));
      end else if ($urandom_range(9) == 0) begin
        send_request(kind, 20'($urandom), 6'($urandom), 1'($urandom));
      end else begin
        send_request(kind, pick_page(), 6'($urandom_range(3)),
                     1'($urandom_range(5) == 0));
      end
    end
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_output = 1'b1;
        repeat (300) @(negedge clk);
        hold_output = 1'b0;
      end
      for (int n = 0; n < 6; n++)
        send_request(n[0] ? REQ_SEARCH : REQ_INSERT, 20'(n), 6'(n), 1'b0, 1);
    join
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    test_full_table();
    repeat (FRAMES) send_request(REQ_EVICT, 20'h0, 6'h0, 1'b0);
    wait_drained();
    test_backpressure();
    test_random(300);
    wait_drained();
    repeat (20) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/ftcr_pkg.sv
rtl/ftcr_ram.sv
rtl/frame_table_clock_replacement_unit.sv
tb/testbench.sv
